FILE: src/sapq_pkg.sv
// Shared types, codes and the ordering function of the sorted-array priority queue.
package sapq_pkg;

    // Default number of entries the queue can hold.
    localparam int DEFAULT_CAPACITY = 8;

    // Width of one held value.
    localparam int VALUE_W = 32;

    // Transaction modes on the mode port.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TAKE   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_TAKE,
        OP_LOAD,
        OP_SORT
    } cell_op_t;

    // Control common to all cells.
    typedef struct packed {
        cell_op_t op;
        logic     largest_first;
    } cell_ctrl_t;

    // True when a must stand in front of b under the given order.
    function automatic logic goes_before(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b,
        input logic                      largest_first
    );
        goes_before = largest_first ? (a > b) : (a < b);
    endfunction

endpackage

FILE: src/sapq_cell.sv
// One storage cell of the queue row: holds one entry and trades it with its neighbors.
module sapq_cell
    import sapq_pkg::*;
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic                      valid,
    input  logic                      load_here,
    input  logic                      pair_left,
    input  logic signed [VALUE_W-1:0] ins_value,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic                      left_b,
    input  logic                      left_s,
    input  logic signed [VALUE_W-1:0] right_value,
    input  logic                      right_valid,
    output logic signed [VALUE_W-1:0] value,
    output logic                      b,
    output logic                      s
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // The new value belongs at or in front of this cell; an empty cell always qualifies.
    assign b = !valid || goes_before(ins_value, value_reg, ctrl.largest_first);

    // The right neighbor's entry belongs in front of this one.
    assign s = right_valid && goes_before(right_value, value_reg, ctrl.largest_first);

    assign value = value_reg;

    // Next entry of this cell for each row operation.
    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (b)
                begin
                    value_next = left_b ? left_value : ins_value;
                end
            end
            OP_TAKE:
            begin
                value_next = right_value;
            end
            OP_LOAD:
            begin
                if (load_here)
                begin
                    value_next = ins_value;
                end
            end
            OP_SORT:
            begin
                if (pair_left && s)
                begin
                    value_next = right_value;
                end
                else if (!pair_left && left_s)
                begin
                    value_next = left_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Entry storage; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: src/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue: control, count and the row of cells.
//
//  Channel   | Ports                        | Transaction taken when
//  ----------+------------------------------+-------------------------------
//  command   | start, busy, mode, value     | start high and busy low
//  result    | done, status, taken_value    | done high (one cycle, no stall)
//  config    | cfg_we, cfg_wdata            | cfg_we high
//
// A take, a refused command or an insert in the order the entries are already
// sorted in needs no sort pass; done follows on the next cycle and a new
// command may be taken at once. An insert after the order changed loads the
// value at the tail and runs CAPACITY odd-even transposition phases over the
// cells: busy is high through those phases and done is set as the last phase
// ends. Reset clears the count, the order and the control; entry contents are
// not reset. Results cannot be stalled.
module sorted_array_priority_queue
    import sapq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      mode,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] taken_value,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic {
        S_RUN,
        S_SORT
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             count_reg;
    logic [PW-1:0]             phase_cnt_reg;
    logic                      largest_first_reg;
    logic                      sorted_dir_reg;
    logic                      done_reg;
    logic [1:0]                status_reg;
    logic signed [VALUE_W-1:0] taken_value_reg;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      same_order;
    logic                      last_phase;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_b     [CAPACITY];
    logic                      cell_s     [CAPACITY];
    logic                      cell_valid [CAPACITY];

    assign busy        = (state_reg == S_SORT);
    assign done        = done_reg;
    assign status      = status_reg;
    assign taken_value = taken_value_reg;

    assign accept     = start && !busy;
    assign full       = (count_reg == CW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign same_order = (largest_first_reg == sorted_dir_reg);
    assign last_phase = (phase_cnt_reg == PW'(CAPACITY - 1));

    // Row operation for this cycle.
    always_comb
    begin
        ctrl.op            = OP_HOLD;
        ctrl.largest_first = largest_first_reg;
        if (busy)
        begin
            ctrl.op = OP_SORT;
        end
        else if (accept)
        begin
            if (mode == MODE_INSERT && !full)
            begin
                ctrl.op = same_order ? OP_INSERT : OP_LOAD;
            end
            else if (mode == MODE_TAKE && !empty)
            begin
                ctrl.op = OP_TAKE;
            end
        end
    end

    // Row of cells, each wired to the neighbors it has.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic                      left_b;
        logic                      left_s;
        logic signed [VALUE_W-1:0] right_value;
        logic                      right_valid;

        assign cell_valid[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_value = '0;
            assign left_b     = 1'b0;
            assign left_s     = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_b     = cell_b[i-1];
            assign left_s     = cell_s[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = cell_value[i];
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        sapq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (cell_valid[i]),
            .load_here   (CW'(i) == count_reg),
            .pair_left   ((i % 2 == 0) ? !phase_cnt_reg[0] : phase_cnt_reg[0]),
            .ins_value   (value),
            .left_value  (left_value),
            .left_b      (left_b),
            .left_s      (left_s),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[i]),
            .b           (cell_b[i]),
            .s           (cell_s[i])
        );
    end

    // Control state, count, order and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_RUN;
            count_reg         <= '0;
            phase_cnt_reg     <= '0;
            largest_first_reg <= 1'b0;
            sorted_dir_reg    <= 1'b0;
            done_reg          <= 1'b0;
            status_reg        <= ST_DONE;
            taken_value_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                largest_first_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_RUN:
                begin
                    if (accept)
                    begin
                        if (mode == MODE_INSERT)
                        begin
                            taken_value_reg <= '0;
                            if (full)
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_FULL;
                            end
                            else if (same_order)
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_DONE;
                                count_reg  <= count_reg + CW'(1);
                            end
                            else
                            begin
                                done_reg      <= 1'b0;
                                status_reg    <= ST_DONE;
                                count_reg     <= count_reg + CW'(1);
                                phase_cnt_reg <= '0;
                                state_reg     <= S_SORT;
                            end
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                            if (empty)
                            begin
                                status_reg      <= ST_EMPTY;
                                taken_value_reg <= '0;
                            end
                            else
                            begin
                                status_reg      <= ST_DONE;
                                count_reg       <= count_reg - CW'(1);
                                taken_value_reg <= cell_value[0];
                            end
                        end
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                S_SORT:
                begin
                    phase_cnt_reg <= phase_cnt_reg + PW'(1);
                    if (last_phase)
                    begin
                        state_reg      <= S_RUN;
                        sorted_dir_reg <= largest_first_reg;
                        done_reg       <= 1'b1;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_RUN;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count exceeds capacity");

    // A refused transaction never reports a value.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_DONE) |-> (taken_value_reg == '0))
        else $error("refused transaction carries a value");

    // A sort pass starts only from an accepted insert.
    a_sort_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(accept && mode == MODE_INSERT))
        else $error("sort pass without an insert");

    // The end of a sort pass delivers its result.
    a_sort_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done_reg)
        else $error("sort pass ended without a result");

    // The sorted order changes only when a sort pass completes.
    a_dir_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sorted_dir_reg) |-> (done_reg && !busy))
        else $error("sorted order changed outside a sort pass");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the sorted-array priority queue: directed table, then random traffic.
module tb
    import sapq_pkg::*;
();

    localparam int QCAP        = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SEGMENTS    = 9;
    localparam int SEG_ITEMS   = 90;

    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct {
        row_kind_t                 kind;
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic                      typed;
        logic [1:0]                exp_status;
        logic signed [VALUE_W-1:0] exp_taken;
    } dir_row_t;

    // Expected contents of one result transaction.
    typedef struct {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] taken;
    } queue_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] taken_value;
    logic                      cfg_we;
    logic                      cfg_wdata;

    // Shadow copy of the queue contents and the order register.
    logic signed [VALUE_W-1:0] shadow_entries [QCAP];
    int                        shadow_count;
    logic                      shadow_largest_first;

    queue_result_t awaited_results [$];
    dir_row_t      dir_table [$];
    int            failures = 0;
    int            cycles = 0;

    sorted_array_priority_queue #(
        .CAPACITY(QCAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .value(value),
        .done(done),
        .status(status),
        .taken_value(taken_value),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Free-running clock with a period of 10.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Applies one command to the shadow queue and returns the result it must produce.
    task automatic shadow_step(
        input  logic                      cmd_mode,
        input  logic signed [VALUE_W-1:0] cmd_value,
        output queue_result_t             res
    );
        logic signed [VALUE_W-1:0] held;
        int                        j;
        res.status = ST_DONE;
        res.taken  = '0;
        if (cmd_mode == MODE_INSERT)
        begin
            if (shadow_count >= QCAP)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                shadow_entries[shadow_count] = cmd_value;
                shadow_count++;
                // A successful insert re-sorts every held entry by the current order.
                for (int i = 1; i < shadow_count; i++)
                begin
                    held = shadow_entries[i];
                    j = i;
                    while (j > 0 && (shadow_largest_first ? (held > shadow_entries[j-1])
                                                          : (held < shadow_entries[j-1])))
                    begin
                        shadow_entries[j] = shadow_entries[j-1];
                        j--;
                    end
                    shadow_entries[j] = held;
                end
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.taken = shadow_entries[0];
                for (int i = 0; i + 1 < shadow_count; i++)
                begin
                    shadow_entries[i] = shadow_entries[i+1];
                end
                shadow_count--;
            end
        end
    endtask

    // Drives one command transaction and records its expected result once it is taken.
    task automatic send_command(
        input logic                      cmd_mode,
        input logic signed [VALUE_W-1:0] cmd_value,
        input logic                      typed,
        input queue_result_t             typed_res
    );
        queue_result_t res;
        start <= 1'b1;
        mode  <= cmd_mode;
        value <= cmd_value;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        shadow_step(cmd_mode, cmd_value, res);
        awaited_results.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    // Writes the order register once the queue has finished all outstanding work.
    task automatic write_order(input logic lf);
        start <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lf;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_largest_first = lf;
    endtask

    // Leaves start low for a random number of cycles.
    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    function automatic dir_row_t make_row(
        input row_kind_t                 kind,
        input logic                      m,
        input logic signed [VALUE_W-1:0] v,
        input logic                      typed,
        input logic [1:0]                st,
        input logic signed [VALUE_W-1:0] tv
    );
        dir_row_t r;
        r.kind       = kind;
        r.mode       = m;
        r.value      = v;
        r.typed      = typed;
        r.exp_status = st;
        r.exp_taken  = tv;
        return r;
    endfunction

    // Random values lean on the extremes and on a narrow band that produces ties.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int pick;
        int near;
        pick = $urandom_range(0, 9);
        near = $urandom_range(0, 20);
        case (pick)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return near - 10;
            default: return $urandom;
        endcase
    endfunction

    // Result checker: each strobed result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d, taken_value %0d",
                       status, taken_value);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    failures++;
                end
                if (taken_value !== want.taken)
                begin
                    $error("taken_value mismatch: expected %0d, actual %0d",
                           want.taken, taken_value);
                    failures++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random segments, drain.
    initial
    begin
        queue_result_t typed_res;
        queue_result_t no_res;
        dir_row_t      row;
        int            idle_pct;
        int            insert_pct;
        logic          lf;
        logic          m;

        shadow_count         = 0;
        shadow_largest_first = 1'b0;
        rst_n                = 1'b0;
        start                = 1'b0;
        mode                 = MODE_INSERT;
        value                = '0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        no_res.status        = ST_DONE;
        no_res.taken         = '0;
        for (int i = 0; i < QCAP; i++)
        begin
            shadow_entries[i] = '0;
        end

        // Directed table: empty take, extremes, a full queue, an order change with
        // entries held, ties and alternating bit patterns.
        dir_table.push_back(make_row(ROW_CFG, MODE_INSERT, 0, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, 0, 1, ST_EMPTY, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 32'sh7FFF_FFFF, 1, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 32'sh8000_0000, 1, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 0, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, -1, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 1, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 5, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 5, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, -100, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 42, 1, ST_FULL, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, -7, 1, ST_DONE, 32'sh8000_0000));
        dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, 0, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CFG, MODE_INSERT, 1, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, 0, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 3, 0, ST_DONE, 0));
        for (int i = 0; i < 6; i++)
        begin
            dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, 32'shFFFF_FFFF, 0, ST_DONE, 0));
        end
        dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, 0, 1, ST_EMPTY, 0));
        dir_table.push_back(make_row(ROW_CFG, MODE_INSERT, 0, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 32'sh5555_5555, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_INSERT, 32'shAAAA_AAAA, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, 0, 0, ST_DONE, 0));
        dir_table.push_back(make_row(ROW_CMD, MODE_TAKE, 0, 0, ST_DONE, 0));

        // Hold reset low, then release it on a falling edge.
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table; configuration rows carry the order in the value field.
        foreach (dir_table[i])
        begin
            row = dir_table[i];
            if (row.kind == ROW_CFG)
            begin
                write_order(row.value[0]);
            end
            else
            begin
                typed_res.status = row.exp_status;
                typed_res.taken  = row.exp_taken;
                send_command(row.mode, row.value, row.typed, typed_res);
            end
        end

        // Random segments: the insert bias changes per segment, the sender gap rate every
        // three segments, and the order register is rewritten before each segment.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_pct   = (seg < 3) ? 21 : ((seg < 6) ? 63 : 0);
            insert_pct = (seg % 3 == 0) ? 75 : ((seg % 3 == 1) ? 30 : 52);
            if (seg == 0)
            begin
                lf = 1'b1;
            end
            else if (seg == 1)
            begin
                lf = 1'b0;
            end
            else
            begin
                lf = 1'($urandom_range(0, 1));
            end
            write_order(lf);
            for (int k = 0; k < SEG_ITEMS; k++)
            begin
                sender_gap(idle_pct);
                m = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_TAKE;
                send_command(m, random_value(), 1'b0, no_res);
            end
        end

        // Drain the outstanding results, then allow for the longest insert.
        start <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (QCAP + 4) @(negedge clk);

        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
